>>> src/ptw_pkg.sv
package ptw_pkg;

  localparam int unsigned FRAMES_DEF = 16;
  localparam int unsigned ENTRY_W    = 64;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned OFF_W      = 12;
  localparam int unsigned VA_W       = 48;
  localparam int unsigned PA_W       = 52;
  localparam int unsigned PFN_W      = PA_W - OFF_W;
  localparam int unsigned ROOT_W     = 4;

  localparam logic [OFF_W-1:0] NEW_FLAGS = 12'h007;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_MAP       = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NOT_MAPPED = 2'd1,
    STATUS_NO_FRAME   = 2'd2
  } status_e;

endpackage

>>> src/ptw_if.sv
interface ptw_req_if;
  import ptw_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [VA_W-1:0]   vaddr;
  logic [PA_W-1:0]   paddr;
  modport source (output valid, output operation, output vaddr, output paddr,
                  input ready);
  modport sink   (input valid, input operation, input vaddr, input paddr,
                  output ready);
endinterface

interface ptw_rsp_if;
  import ptw_pkg::*;
  logic              valid;
  logic              ready;
  status_e           status;
  logic [PA_W-1:0]   phys_result;
  logic [OFF_W-1:0]  page_flags;
  modport source (output valid, output status, output phys_result, output page_flags,
                  input ready);
  modport sink   (input valid, input status, input phys_result, input page_flags,
                  output ready);
endinterface

interface ptw_cfg_if;
  import ptw_pkg::*;
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] root_frame;
  modport source (output valid, output root_frame, input ready);
  modport sink   (input valid, input root_frame, output ready);
endinterface

>>> src/ptw_tbl.sv
module ptw_tbl #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 addr_i,
  input  logic [ptw_pkg::ENTRY_W-1:0]   wdata_i,
  output logic [ptw_pkg::ENTRY_W-1:0]   rdata_o
);
  import ptw_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ptw_frame_mod.sv
module ptw_frame_mod #(
  parameter int unsigned FRAMES = ptw_pkg::FRAMES_DEF,
  parameter int unsigned FW     = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ptw_pkg::PFN_W-1:0]  value_i,
  output logic                       busy_o,
  output logic [FW-1:0]              result_o
);
  import ptw_pkg::*;

  // value mod FRAMES: fold 8-bit chunks weighted by 2^(8k) mod FRAMES,
  // divide the folded sum by reciprocal multiplication, subtract quotient * FRAMES
  localparam int unsigned CH_W     = 8;
  localparam int unsigned CHUNKS   = PFN_W / CH_W;
  localparam int unsigned SUM_W    = CH_W + FW + 3;
  localparam int unsigned SH       = SUM_W + FW;
  localparam int unsigned RCP_W    = SUM_W + 2;
  localparam int unsigned PROD_W   = SUM_W + RCP_W;
  localparam int unsigned QW       = PROD_W - SH;
  localparam longint unsigned RCP_VAL =
    ((64'd1 << SH) + 64'(FRAMES) - 64'd1) / 64'(FRAMES);
  localparam logic [RCP_W-1:0] RCP      = RCP_W'(RCP_VAL);
  localparam logic [SUM_W-1:0] FRAMES_S = SUM_W'(FRAMES);
  localparam logic [1:0]       STEPS    = 2'd2;

  function automatic logic [FW-1:0] chunk_weight(int unsigned k);
    int unsigned w;
    w = 1;
    for (int unsigned j = 0; j < k * CH_W; j++) begin
      w = w * 2;
      if (w >= FRAMES) begin
        w = w - FRAMES;
      end
    end
    return FW'(w);
  endfunction

  logic [1:0]        cnt_q;
  logic [SUM_W-1:0]  sum_d;
  logic [SUM_W-1:0]  sum_q;
  logic [PROD_W-1:0] prod;
  logic [QW-1:0]     quo_q;
  logic [SUM_W-1:0]  rem_full;
  logic [FW-1:0]     rem_q;

  always_comb begin
    sum_d = '0;
    for (int unsigned k = 0; k < CHUNKS; k++) begin
      sum_d = sum_d + SUM_W'(value_i[k*CH_W +: CH_W]) * SUM_W'(chunk_weight(k));
    end
  end

  assign prod     = {{(PROD_W-SUM_W){1'b0}}, sum_q} * {{(PROD_W-RCP_W){1'b0}}, RCP};
  assign rem_full = sum_q - SUM_W'(quo_q) * FRAMES_S;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= STEPS;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // registered in order: sum on start, then quotient from sum_q, then remainder from sum_q and quo_q
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= sum_d;
    end
    quo_q <= prod[PROD_W-1:SH];
    rem_q <= rem_full[FW-1:0];
  end

  assign busy_o   = (cnt_q != '0);
  assign result_o = rem_q;

endmodule

>>> src/page_table_walk_map_translate_unit.sv
// four-level page table walker with an internal table memory of FRAMES frames x 512 entries
//
// req_i carries one item: operation (translate or map), vaddr, paddr.
// rsp_o returns one item per request: status, phys_result, page_flags.
// cfg_i writes root_frame, always ready; user must write it only while idle, not enforced.
//
// each level takes a table read state and a check state on the single-port table
// memory, then the done state loads the output register once rsp_o is free; the next
// request item is accepted only after that, so one walk runs at a time. a walk that
// stops early is shorter.
// a level whose entry points at a frame number of FRAMES or more adds the mod state, which
// waits for the reduction of that frame number modulo FRAMES.
//
// after reset the block sweeps all FRAMES*512 entries of the table memory to zero, one
// entry per cycle; req_i stays not ready until the sweep is done.
// a stalled rsp_o holds its item; one finished walk can wait behind it.
module page_table_walk_map_translate_unit #(
  parameter int unsigned FRAMES = ptw_pkg::FRAMES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ptw_req_if.sink       req_i,
  ptw_rsp_if.source     rsp_o,
  ptw_cfg_if.sink       cfg_i
);
  import ptw_pkg::*;

  localparam int unsigned FW    = $clog2(FRAMES);
  localparam int unsigned AW    = FW + IDX_W;
  localparam int unsigned DEPTH = FRAMES * (2 ** IDX_W);
  localparam int unsigned RW    = (FW + 1 > ROOT_W) ? FW + 1 : ROOT_W;

  localparam logic [1:0] LAST_LVL = 2'd3;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [AW-1:0]      clr_q;
  logic [ROOT_W-1:0]  root_q;
  logic [FW-1:0]      alloc_q;

  logic               op_q;
  logic [VA_W-1:0]    va_q;
  logic [PA_W-1:0]    pa_q;
  logic [1:0]         lvl_q;
  logic [FW-1:0]      frame_q;

  status_e            res_status_q;
  logic [PA_W-1:0]    res_phys_q;
  logic [OFF_W-1:0]   res_flags_q;

  logic               out_valid_q;
  status_e            out_status_q;
  logic [PA_W-1:0]    out_phys_q;
  logic [OFF_W-1:0]   out_flags_q;

  logic [RW-1:0]      root_red;
  logic [FW-1:0]      root_mod;
  logic [IDX_W-1:0]   idx;
  logic               tbl_we;
  logic [AW-1:0]      tbl_addr;
  logic [ENTRY_W-1:0] tbl_wdata;
  logic [ENTRY_W-1:0] tbl_rdata;
  logic               present;
  logic [PFN_W-1:0]   pfn;
  logic               pfn_small;
  logic               alloc_full;
  logic [FW-1:0]      new_frame;
  logic               mod_start;
  logic               mod_busy;
  logic [FW-1:0]      mod_result;
  logic               out_free;

  // root frame mod FRAMES, root is at most 15 and FRAMES at least 4
  always_comb begin
    root_red = RW'(root_q);
    for (int i = 0; i < 3; i++) begin
      if (root_red >= RW'(FRAMES)) begin
        root_red = root_red - RW'(FRAMES);
      end
    end
  end
  assign root_mod = root_red[FW-1:0];

  always_comb begin
    case (lvl_q)
      2'd0:    idx = va_q[47:39];
      2'd1:    idx = va_q[38:30];
      2'd2:    idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  assign present    = tbl_rdata[0];
  assign pfn        = tbl_rdata[PA_W-1:OFF_W];
  assign pfn_small  = (pfn < PFN_W'(FRAMES));
  assign alloc_full = (alloc_q >= FW'(FRAMES - 1));
  assign new_frame  = (alloc_q < root_mod) ? alloc_q : alloc_q + FW'(1);
  assign out_free   = !out_valid_q || rsp_o.ready;

  // memory port: sweep on clear, otherwise the current slot
  always_comb begin
    tbl_we    = 1'b0;
    tbl_addr  = {frame_q, idx};
    tbl_wdata = '0;
    if (state_q == S_CLEAR) begin
      tbl_we   = 1'b1;
      tbl_addr = clr_q;
    end else if (state_q == S_CHECK) begin
      if (lvl_q == LAST_LVL) begin
        if (op_q == OP_MAP) begin
          tbl_we    = 1'b1;
          tbl_wdata = {{(ENTRY_W-PA_W){1'b0}}, pa_q[PA_W-1:OFF_W], NEW_FLAGS};
        end
      end else if (!present && op_q == OP_MAP && !alloc_full) begin
        tbl_we    = 1'b1;
        tbl_wdata = {{(ENTRY_W-OFF_W-FW){1'b0}}, new_frame, NEW_FLAGS};
      end
    end
  end

  assign mod_start = (state_q == S_CHECK) && (lvl_q != LAST_LVL) && present && !pfn_small;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      S_IDLE:  if (req_i.valid) state_d = S_READ;
      S_READ:  state_d = S_CHECK;
      S_CHECK: begin
        if (lvl_q == LAST_LVL) begin
          state_d = S_DONE;
        end else if (!present) begin
          state_d = (op_q == OP_TRANSLATE || alloc_full) ? S_DONE : S_READ;
        end else begin
          state_d = pfn_small ? S_READ : S_MOD;
        end
      end
      S_MOD:   if (!mod_busy) state_d = S_READ;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      root_q      <= '0;
      alloc_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cfg_i.valid) begin
        root_q <= cfg_i.root_frame;
      end
      if (state_q == S_CHECK && lvl_q != LAST_LVL && !present
          && op_q == OP_MAP && !alloc_full) begin
        alloc_q <= alloc_q + FW'(1);
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q         <= req_i.operation;
        va_q         <= req_i.vaddr;
        pa_q         <= req_i.paddr;
        lvl_q        <= '0;
        frame_q      <= root_mod;
        res_status_q <= STATUS_OK;
        res_phys_q   <= '0;
        res_flags_q  <= '0;
      end
      S_CHECK: begin
        if (lvl_q == LAST_LVL) begin
          if (op_q == OP_TRANSLATE) begin
            if (!present) begin
              res_status_q <= STATUS_NOT_MAPPED;
            end else begin
              res_phys_q  <= {pfn, va_q[OFF_W-1:0]};
              res_flags_q <= tbl_rdata[OFF_W-1:0];
            end
          end
        end else if (!present) begin
          if (op_q == OP_TRANSLATE) begin
            res_status_q <= STATUS_NOT_MAPPED;
          end else if (alloc_full) begin
            res_status_q <= STATUS_NO_FRAME;
          end else begin
            frame_q <= new_frame;
            lvl_q   <= lvl_q + 2'd1;
          end
        end else begin
          if (pfn_small) begin
            frame_q <= pfn[FW-1:0];
          end
          lvl_q <= lvl_q + 2'd1;
        end
      end
      S_MOD: begin
        if (!mod_busy) begin
          frame_q <= mod_result;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_status_q <= res_status_q;
          out_phys_q   <= res_phys_q;
          out_flags_q  <= res_flags_q;
        end
      end
      default: ;
    endcase
  end

  ptw_tbl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .addr_i  (tbl_addr),
    .wdata_i (tbl_wdata),
    .rdata_o (tbl_rdata)
  );

  ptw_frame_mod #(
    .FRAMES (FRAMES),
    .FW     (FW)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mod_start),
    .value_i  (pfn),
    .busy_o   (mod_busy),
    .result_o (mod_result)
  );

  assign req_i.ready       = (state_q == S_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.phys_result = out_phys_q;
  assign rsp_o.page_flags  = out_flags_q;

endmodule
